FILE: src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check an implication on every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/sfre_pkg.sv
`default_nettype none
package sfre_pkg;

    localparam logic [2:0] CMD_FILL   = 3'd0;
    localparam logic [2:0] CMD_SET    = 3'd1;
    localparam logic [2:0] CMD_CIRCLE = 3'd2;
    localparam logic [2:0] CMD_RECT   = 3'd3;
    localparam logic [2:0] CMD_TRI    = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;

    localparam logic [0:0] REG_WIDTH  = 1'd0;
    localparam logic [0:0] REG_HEIGHT = 1'd1;

    localparam logic [31:0] SQRT3_Q24 = 32'd29058990;

    typedef struct packed {
        logic [2:0] cmd;
        logic [8:0] x_first;
        logic [8:0] y_first;
        logic [8:0] x_second;
        logic [8:0] y_second;
        logic [7:0] extent;
        logic [7:0] shade;
    } req_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       drawn;
    } rsp_t;

endpackage
`default_nettype wire

FILE: src/sfre_ram.sv
`default_nettype none
module sfre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: src/shape_fill_raster_engine.sv
// Commands pass setup and prepare, then scan (set pixel, shapes), read (read pixel) or,
// if rejected, done. Shapes scan their box: fill W*H, rectangle its area, circle (2r+1)^2,
// triangle (2*floor(s/2)+1)*height, at one frame-store write port access per cycle.
// One request in flight; the next is taken once the result is in the output register.
// Reset (synchronous, aresetn low) clears control state and sets width and height to
// 256 clamped to the maximum; frame contents are undefined until written.
`default_nettype none
`include "assert_macros.svh"
module shape_fill_raster_engine import sfre_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire req_t       s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output rsp_t            m_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    typedef enum logic [2:0] {ST_IDLE, ST_SETUP, ST_PREP, ST_SCAN, ST_READ, ST_DONE} state_t;
    typedef enum logic [1:0] {SH_PLAIN, SH_CIRC, SH_TRI} shape_t;

    state_t state_reg;
    shape_t shape_reg;
    req_t   req_reg;
    rsp_t   m_data_reg;
    logic   m_valid_reg;
    logic [8:0] w_reg, h_reg;
    logic [15:0] rr_reg;
    logic [7:0]  hgt_reg;
    logic [9:0]  x_reg, y_reg, x_start_reg, x_end_reg, y_end_reg;
    logic        y_down_reg;
    logic signed [9:0] dx_reg, dx_start_reg, dy_reg;
    logic [16:0] acc_x_reg, acc_y_reg, accx_start_reg;
    logic [7:0]  pix_reg;
    logic        ok_reg;

    logic [6:0]  half;
    logic [31:0] hgt_prod;
    logic [9:0]  wx, hx, x1, y1, x2, y2, ex, sp;
    logic        ok_set, ok_circ, ok_rect, ok_tri;
    logic [9:0]  xl, xh, yl, yh;
    logic signed [18:0] cx_step, cy_step;
    logic [17:0] circ_sum;
    logic        pred, clip, ram_we, ram_re;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  rdata;

    assign half     = req_reg.extent[7:1];
    assign hgt_prod = SQRT3_Q24 * {25'd0, half};
    assign wx = {1'b0, w_reg};
    assign hx = {1'b0, h_reg};
    assign x1 = {1'b0, req_reg.x_first};
    assign y1 = {1'b0, req_reg.y_first};
    assign x2 = {1'b0, req_reg.x_second};
    assign y2 = {1'b0, req_reg.y_second};
    assign ex = {2'b00, req_reg.extent};
    assign sp = {2'b00, half, 1'b0};

    assign ok_set  = (x1 < wx) && (y1 < hx);
    assign ok_circ = (ex != 10'd0) && (x1 >= ex) && (y1 >= ex)
                     && ({1'b0, x1} + {1'b0, ex} <= {1'b0, wx})
                     && ({1'b0, y1} + {1'b0, ex} <= {1'b0, hx});
    assign ok_rect = (x1 <= wx) && (y1 <= hx) && (x2 <= wx) && (y2 <= hx)
                     && (x1 != x2) && (y1 != y2);
    assign ok_tri  = ({1'b0, x1} + {1'b0, ex} <= {1'b0, wx}) && (y1 <= hx)
                     && ({2'b00, hgt_reg} <= y1);
    assign xl = (x1 < x2) ? x1 : x2;
    assign xh = (x1 < x2) ? x2 : x1;
    assign yl = (y1 < y2) ? y1 : y2;
    assign yh = (y1 < y2) ? y2 : y1;

    assign cx_step  = $signed({2'b00, acc_x_reg}) + 19'($signed({dx_reg, 1'b1}));
    assign cy_step  = $signed({2'b00, acc_y_reg}) + 19'($signed({dy_reg, 1'b1}));
    assign circ_sum = {1'b0, acc_x_reg} + {1'b0, acc_y_reg};

    always_comb begin
        case (shape_reg)
            SH_CIRC: pred = circ_sum <= {2'b00, rr_reg};
            SH_TRI:  pred = acc_x_reg > acc_y_reg;
            default: pred = 1'b1;
        endcase
    end

    assign clip   = (x_reg < wx) && (y_reg < hx);
    assign ram_we = (state_reg == ST_SCAN) && pred && clip;
    assign ram_re = (state_reg == ST_PREP) && (req_reg.cmd == CMD_READ) && ok_set;
    assign waddr  = AW'(y_reg * MAX_WIDTH + x_reg);
    assign raddr  = AW'(y1 * MAX_WIDTH + x1);

    sfre_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_frame (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (req_reg.shade),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            w_reg       <= 9'(W_RST);
            h_reg       <= 9'(H_RST);
        end else begin
            if (cfg_we && cfg_index[1] == 1'b0) begin
                if (cfg_index[0] == REG_WIDTH) begin
                    if (cfg_wdata == 9'd0) w_reg <= 9'd1;
                    else if ({23'd0, cfg_wdata} > MAX_WIDTH) w_reg <= 9'(MAX_WIDTH);
                    else w_reg <= cfg_wdata;
                end else begin
                    if (cfg_wdata == 9'd0) h_reg <= 9'd1;
                    else if ({23'd0, cfg_wdata} > MAX_HEIGHT) h_reg <= 9'(MAX_HEIGHT);
                    else h_reg <= cfg_wdata;
                end
            end
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_data;
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    rr_reg    <= req_reg.extent * req_reg.extent;
                    hgt_reg   <= hgt_prod[31:24];
                    state_reg <= ST_PREP;
                end
                ST_PREP: begin
                    pix_reg        <= 8'd0;
                    ok_reg         <= 1'b0;
                    shape_reg      <= SH_PLAIN;
                    y_down_reg     <= 1'b0;
                    dx_start_reg   <= 10'sd0;
                    dx_reg         <= 10'sd0;
                    dy_reg         <= 10'sd0;
                    accx_start_reg <= 17'd0;
                    acc_x_reg      <= 17'd0;
                    acc_y_reg      <= 17'd0;
                    state_reg      <= ST_DONE;
                    case (req_reg.cmd)
                        CMD_FILL: begin
                            ok_reg      <= 1'b1;
                            x_reg       <= 10'd0;
                            x_start_reg <= 10'd0;
                            x_end_reg   <= wx - 10'd1;
                            y_reg       <= 10'd0;
                            y_end_reg   <= hx - 10'd1;
                            state_reg   <= ST_SCAN;
                        end
                        CMD_SET: begin
                            ok_reg      <= ok_set;
                            x_reg       <= x1;
                            x_start_reg <= x1;
                            x_end_reg   <= x1;
                            y_reg       <= y1;
                            y_end_reg   <= y1;
                            if (ok_set) state_reg <= ST_SCAN;
                        end
                        CMD_CIRCLE: begin
                            ok_reg         <= ok_circ;
                            shape_reg      <= SH_CIRC;
                            x_reg          <= x1 - ex;
                            x_start_reg    <= x1 - ex;
                            x_end_reg      <= x1 + ex;
                            y_reg          <= y1 - ex;
                            y_end_reg      <= y1 + ex;
                            dx_start_reg   <= -$signed(ex);
                            dx_reg         <= -$signed(ex);
                            dy_reg         <= -$signed(ex);
                            accx_start_reg <= {1'b0, rr_reg};
                            acc_x_reg      <= {1'b0, rr_reg};
                            acc_y_reg      <= {1'b0, rr_reg};
                            if (ok_circ) state_reg <= ST_SCAN;
                        end
                        CMD_RECT: begin
                            ok_reg      <= ok_rect;
                            x_reg       <= xl;
                            x_start_reg <= xl;
                            x_end_reg   <= xh - 10'd1;
                            y_reg       <= yl;
                            y_end_reg   <= yh - 10'd1;
                            if (ok_rect) state_reg <= ST_SCAN;
                        end
                        CMD_TRI: begin
                            ok_reg      <= ok_tri;
                            shape_reg   <= SH_TRI;
                            y_down_reg  <= 1'b1;
                            x_reg       <= x1;
                            x_start_reg <= x1;
                            x_end_reg   <= x1 + sp;
                            y_reg       <= y1;
                            y_end_reg   <= y1 - {2'b00, hgt_reg} + 10'd1;
                            if (ok_tri && hgt_reg != 8'd0) state_reg <= ST_SCAN;
                        end
                        CMD_READ: begin
                            ok_reg <= ok_set;
                            if (ok_set) state_reg <= ST_READ;
                        end
                        default: begin
                            ok_reg <= 1'b0;
                        end
                    endcase
                end
                ST_SCAN: begin
                    if (x_reg == x_end_reg) begin
                        if (y_reg == y_end_reg) begin
                            state_reg <= ST_DONE;
                        end else begin
                            x_reg     <= x_start_reg;
                            dx_reg    <= dx_start_reg;
                            acc_x_reg <= accx_start_reg;
                            y_reg     <= y_down_reg ? y_reg - 10'd1 : y_reg + 10'd1;
                            dy_reg    <= dy_reg + 10'sd1;
                            acc_y_reg <= (shape_reg == SH_TRI) ? acc_y_reg + {10'd0, half}
                                                               : cy_step[16:0];
                        end
                    end else begin
                        x_reg  <= x_reg + 10'd1;
                        dx_reg <= dx_reg + 10'sd1;
                        if (shape_reg == SH_TRI) begin
                            if (dx_reg < $signed({3'b000, half})) begin
                                acc_x_reg <= acc_x_reg + {9'd0, hgt_reg};
                            end else begin
                                acc_x_reg <= acc_x_reg - {9'd0, hgt_reg};
                            end
                        end else begin
                            acc_x_reg <= cx_step[16:0];
                        end
                    end
                end
                ST_READ: begin
                    pix_reg   <= rdata;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg            <= 1'b1;
                        m_data_reg.pixel_value <= pix_reg;
                        m_data_reg.drawn       <= ok_reg;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPL(a_write_clipped, aclk, aresetn, ram_we, (x_reg < wx) && (y_reg < hx), "write outside active area")
    `ASSERT_IMPL(a_accept_setup, aclk, aresetn, s_valid && s_ready, ##1 state_reg == ST_SETUP, "accepted request did not start")
    `ASSERT_IMPL(a_zero_undrawn, aclk, aresetn, m_valid && !m_data.drawn, m_data.pixel_value == 8'd0, "nonzero pixel on failed command")

endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;
    import sfre_pkg::*;

    localparam int FB_W = 256;
    localparam int FB_H = 256;
    localparam logic [1:0] IDX_WIDTH  = 2'(REG_WIDTH);
    localparam logic [1:0] IDX_HEIGHT = 2'(REG_HEIGHT);
    localparam logic [1:0] IDX_SPARE  = 2'd2;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [8:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    req_t       s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    rsp_t       m_data;

    shape_fill_raster_engine uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    logic [7:0] frame_img [FB_W*FB_H];
    bit         pix_written [FB_W*FB_H];
    int         cols_in_use = FB_W;
    int         rows_in_use = FB_H;
    rsp_t       pending_rsp [$];
    int         mismatches = 0;
    int         hold_off = 0;
    bit         stall_req = 1'b0;
    bit         stall_done = 1'b0;

    function automatic int clamp_size(logic [8:0] v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic void plot(int x, int y, logic [7:0] v);
        if (x >= 0 && y >= 0 && x < cols_in_use && y < rows_in_use) begin
            frame_img[y*FB_W + x] = v;
            pix_written[y*FB_W + x] = 1'b1;
        end
    endfunction

    function automatic rsp_t draw_command(req_t r);
        rsp_t o;
        int x1, y1, x2, y2, e, wd, ht, half, hgt;
        longint prod;
        o = '0;
        x1 = int'(r.x_first); y1 = int'(r.y_first);
        x2 = int'(r.x_second); y2 = int'(r.y_second);
        e = int'(r.extent); wd = cols_in_use; ht = rows_in_use;
        case (r.cmd)
            CMD_FILL: begin
                for (int j = 0; j < ht; j++)
                    for (int i = 0; i < wd; i++) plot(i, j, r.shade);
                o.drawn = 1'b1;
            end
            CMD_SET: if (x1 < wd && y1 < ht) begin
                plot(x1, y1, r.shade);
                o.drawn = 1'b1;
            end
            CMD_CIRCLE: if (e >= 1 && x1 >= e && y1 >= e && x1 + e <= wd && y1 + e <= ht) begin
                for (int i = -e; i <= e; i++)
                    for (int j = -e; j <= e; j++)
                        if (i*i + j*j <= e*e) plot(x1 + i, y1 + j, r.shade);
                o.drawn = 1'b1;
            end
            CMD_RECT: if (x1 <= wd && y1 <= ht && x2 <= wd && y2 <= ht
                          && x1 != x2 && y1 != y2) begin
                for (int j = (y1 < y2 ? y1 : y2); j < (y1 < y2 ? y2 : y1); j++)
                    for (int i = (x1 < x2 ? x1 : x2); i < (x1 < x2 ? x2 : x1); i++)
                        plot(i, j, r.shade);
                o.drawn = 1'b1;
            end
            CMD_TRI: begin
                half = e / 2;
                prod = longint'(SQRT3_Q24) * half;
                hgt = int'(prod >> 24);
                if (x1 + e <= wd && y1 <= ht && hgt <= y1) begin
                    for (int i = 0; i <= half; i++)
                        for (int j = 0; j < hgt; j++)
                            if (hgt*i > half*j) begin
                                plot(x1 + i, y1 - j, r.shade);
                                plot(x1 + 2*half - i, y1 - j, r.shade);
                            end
                    o.drawn = 1'b1;
                end
            end
            CMD_READ: if (x1 < wd && y1 < ht) begin
                o.pixel_value = frame_img[y1*FB_W + x1];
                o.drawn = 1'b1;
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == IDX_WIDTH) cols_in_use = clamp_size(val, FB_W);
        else if (idx == IDX_HEIGHT) rows_in_use = clamp_size(val, FB_H);
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
        rsp_t p;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = draw_command(r);
        if (typed && p !== typed_rsp) begin
            $error("typed row: expected %h predicted %h", typed_rsp, p);
            mismatches++;
        end
        pending_rsp.push_back(p);
    endtask

    function automatic req_t mk(logic [2:0] c, int x1, int y1, int x2, int y2, int e, int s);
        req_t r;
        r.cmd = c; r.x_first = 9'(x1); r.y_first = 9'(y1); r.x_second = 9'(x2);
        r.y_second = 9'(y2); r.extent = 8'(e); r.shade = 8'(s);
        return r;
    endfunction

    // pick a read that only hits written pixels or lies outside the active area
    function automatic req_t random_read();
        req_t r;
        int k;
        r = '0;
        r.cmd = CMD_READ;
        r.shade = 8'($urandom);
        r.x_second = 9'($urandom); r.y_second = 9'($urandom); r.extent = 8'($urandom);
        for (int t = 0; t < 50; t++) begin
            r.x_first = 9'($urandom); r.y_first = 9'($urandom);
            if (r.x_first >= cols_in_use || r.y_first >= rows_in_use) return r;
            k = int'(r.y_first)*FB_W + int'(r.x_first);
            if (pix_written[k]) return r;
        end
        r.x_first = 9'h1ff;
        return r;
    endfunction

    function automatic req_t random_shape();
        req_t r;
        int pick, e;
        r = '0;
        r.x_second = 9'($urandom); r.y_second = 9'($urandom);
        r.extent = 8'($urandom); r.shade = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 2) r.cmd = CMD_FILL;
        else if (pick < 30) begin
            r.cmd = CMD_SET;
            r.x_first = $urandom_range(0, 3) == 0 ? 9'($urandom)
                                                   : 9'($urandom_range(0, cols_in_use));
            r.y_first = $urandom_range(0, 3) == 0 ? 9'($urandom)
                                                   : 9'($urandom_range(0, rows_in_use));
        end else if (pick < 45) begin
            r.cmd = CMD_CIRCLE;
            e = $urandom_range(0, 12);
            if ($urandom_range(0, 9) == 0) e = $urandom_range(0, 255);
            r.extent = 8'(e);
            r.x_first = $urandom_range(0, 4) == 0 ? 9'($urandom)
                                                   : 9'($urandom_range(0, cols_in_use));
            r.y_first = $urandom_range(0, 4) == 0 ? 9'($urandom)
                                                   : 9'($urandom_range(0, rows_in_use));
        end else if (pick < 60) begin
            r.cmd = CMD_RECT;
            r.x_first = 9'($urandom_range(0, cols_in_use));
            r.y_first = 9'($urandom_range(0, rows_in_use));
            r.x_second = 9'(int'(r.x_first) + int'($urandom_range(0, 20)) - 10);
            r.y_second = 9'(int'(r.y_first) + int'($urandom_range(0, 20)) - 10);
            if ($urandom_range(0, 9) == 0) r.x_second = 9'($urandom);
        end else if (pick < 72) begin
            r.cmd = CMD_TRI;
            e = $urandom_range(0, 24);
            if ($urandom_range(0, 14) == 0) e = $urandom_range(0, 255);
            r.extent = 8'(e);
            r.x_first = 9'($urandom_range(0, cols_in_use));
            r.y_first = $urandom_range(0, 4) == 0 ? 9'($urandom)
                                                   : 9'($urandom_range(0, rows_in_use));
        end else if (pick < 96) r = random_read();
        else begin
            r.cmd = 3'($urandom_range(6, 7));
            r.x_first = 9'($urandom); r.y_first = 9'($urandom);
        end
        return r;
    endfunction

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t rsp;
    } row_t;

    initial begin
        row_t rows [$];
        rsp_t ok, nok;
        ok = '0; ok.drawn = 1'b1;
        nok = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows.push_back('{mk(CMD_FILL, 0, 0, 0, 0, 0, 8'h5a), 1'b1, ok});
        rows.push_back('{mk(CMD_READ, 255, 255, 0, 0, 0, 0), 1'b1, '{8'h5a, 1'b1}});
        rows.push_back('{mk(CMD_SET, 0, 0, 511, 511, 255, 8'hff), 1'b1, ok});
        rows.push_back('{mk(CMD_READ, 0, 0, 0, 0, 0, 0), 1'b1, '{8'hff, 1'b1}});
        rows.push_back('{mk(CMD_SET, 256, 0, 0, 0, 0, 1), 1'b1, nok});
        rows.push_back('{mk(CMD_READ, 511, 511, 511, 511, 255, 255), 1'b1, nok});
        rows.push_back('{mk(CMD_CIRCLE, 10, 10, 0, 0, 0, 3), 1'b1, nok});
        rows.push_back('{mk(CMD_CIRCLE, 10, 10, 0, 0, 10, 3), 1'b0, nok});
        rows.push_back('{mk(CMD_CIRCLE, 9, 20, 0, 0, 10, 3), 1'b1, nok});
        rows.push_back('{mk(CMD_CIRCLE, 246, 246, 0, 0, 10, 4), 1'b0, nok});
        rows.push_back('{mk(CMD_READ, 10, 0, 0, 0, 0, 0), 1'b0, nok});
        rows.push_back('{mk(CMD_RECT, 0, 0, 256, 3, 0, 7), 1'b0, nok});
        rows.push_back('{mk(CMD_RECT, 5, 5, 5, 9, 0, 7), 1'b1, nok});
        rows.push_back('{mk(CMD_RECT, 257, 0, 3, 3, 0, 7), 1'b1, nok});
        rows.push_back('{mk(CMD_RECT, 20, 30, 10, 25, 0, 9), 1'b0, nok});
        rows.push_back('{mk(CMD_READ, 10, 25, 0, 0, 0, 0), 1'b0, nok});
        rows.push_back('{mk(CMD_READ, 20, 25, 0, 0, 0, 0), 1'b0, nok});
        rows.push_back('{mk(CMD_TRI, 0, 0, 0, 0, 0, 11), 1'b0, nok});
        rows.push_back('{mk(CMD_TRI, 0, 20, 0, 0, 21, 12), 1'b0, nok});
        rows.push_back('{mk(CMD_TRI, 0, 5, 0, 0, 20, 12), 1'b1, nok});
        rows.push_back('{mk(CMD_TRI, 240, 255, 0, 0, 255, 13), 1'b1, nok});
        rows.push_back('{mk(CMD_READ, 10, 19, 0, 0, 0, 0), 1'b0, nok});
        rows.push_back('{mk(3'd6, 1, 1, 1, 1, 1, 1), 1'b1, nok});
        rows.push_back('{mk(3'd7, 0, 0, 0, 0, 0, 0), 1'b1, nok});

        foreach (rows[k]) send_request(rows[k].r, rows[k].typed, rows[k].rsp);

        wait_idle();
        write_reg(IDX_SPARE, 9'd5);
        write_reg(IDX_WIDTH, 9'd0);
        write_reg(IDX_HEIGHT, 9'd511);
        send_request(mk(CMD_SET, 0, 5, 0, 0, 0, 8'h33), 1'b1, ok);
        send_request(mk(CMD_SET, 1, 5, 0, 0, 0, 8'h33), 1'b1, nok);
        send_request(mk(CMD_READ, 0, 5, 0, 0, 0, 0), 1'b1, '{8'h33, 1'b1});

        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            case (ph)
                0: begin write_reg(IDX_WIDTH, 9'd256); write_reg(IDX_HEIGHT, 9'd1); end
                1: begin write_reg(IDX_WIDTH, 9'd40); write_reg(IDX_HEIGHT, 9'd30); end
                2: begin
                    write_reg(IDX_WIDTH, 9'($urandom_range(1, 300)));
                    write_reg(IDX_HEIGHT, 9'($urandom_range(1, 300)));
                end
                3: begin write_reg(IDX_WIDTH, 9'd257); write_reg(IDX_HEIGHT, 9'd100); end
                default: begin write_reg(IDX_WIDTH, 9'd256); write_reg(IDX_HEIGHT, 9'd256); end
            endcase
            if (ph == 2) stall_req = 1'b1;
            for (int n = 0; n < 105; n++) send_request(random_shape(), 1'b0, nok);
        end

        wait_idle();
        repeat (200) @(posedge aclk);
        if (pending_rsp.size() != 0) mismatches++;
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    always @(posedge aclk) begin
        if (stall_req && !stall_done) begin
            stall_done <= 1'b1;
            hold_off <= 200;
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            m_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if ($urandom_range(0, 49) == 0) begin
            hold_off <= $urandom_range(10, 60);
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(0, 3) != 0;
        end
    end

    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("result with no request outstanding: %h", m_data);
                mismatches++;
            end else begin
                want = pending_rsp.pop_front();
                if (m_data.pixel_value !== want.pixel_value) begin
                    $error("pixel_value: expected %0d actual %0d",
                           want.pixel_value, m_data.pixel_value);
                    mismatches++;
                end
                if (m_data.drawn !== want.drawn) begin
                    $error("drawn: expected %0d actual %0d", want.drawn, m_data.drawn);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2_000_000_000;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+src
src/sfre_pkg.sv
src/sfre_ram.sv
src/shape_fill_raster_engine.sv
tb/tb.sv
